// ----- sv/ufic_pkg.sv -----
// Package for the unary float/int conversion lane.
// Holds the operation codes and field widths; no dependencies.
package ufic_pkg;
	localparam int CmdW = 4;
	localparam int WordW = 32;
	localparam int CountW = 2;

	localparam logic [CmdW-1:0] CMD_MOV     = 4'd0;
	localparam logic [CmdW-1:0] CMD_NOT     = 4'd1;
	localparam logic [CmdW-1:0] CMD_F32_I32 = 4'd2;
	localparam logic [CmdW-1:0] CMD_F32_U32 = 4'd3;
	localparam logic [CmdW-1:0] CMD_U32_F32 = 4'd4;
	localparam logic [CmdW-1:0] CMD_I32_F32 = 4'd5;
	localparam logic [CmdW-1:0] CMD_F64_I32 = 4'd6;
	localparam logic [CmdW-1:0] CMD_F32_F64 = 4'd7;
	localparam logic [CmdW-1:0] CMD_F64_F32 = 4'd8;
	localparam logic [CmdW-1:0] CMD_TRUNC   = 4'd9;
	localparam logic [CmdW-1:0] CMD_SEXT    = 4'd10;
	localparam logic [CmdW-1:0] CMD_NOP     = 4'd11;

	typedef struct packed {
		logic [WordW-1:0]  dst_lo;
		logic [WordW-1:0]  dst_hi;
		logic [CountW-1:0] write_count;
	} out_item_t;
endpackage

// ----- sv/ufic_if.sv -----
// Valid/ready channel interfaces for the conversion lane.
// Depends on ufic_pkg for the field widths.
interface ufic_in_if;
	logic valid;
	logic ready;
	logic [ufic_pkg::CmdW-1:0] command;
	logic [ufic_pkg::WordW-1:0] src_lo;
	logic [ufic_pkg::WordW-1:0] src_hi;
	modport source (output valid, command, src_lo, src_hi, input ready);
	modport sink (input valid, command, src_lo, src_hi, output ready);
endinterface

interface ufic_out_if;
	logic valid;
	logic ready;
	logic [ufic_pkg::WordW-1:0] dst_lo;
	logic [ufic_pkg::WordW-1:0] dst_hi;
	logic [ufic_pkg::CountW-1:0] write_count;
	modport source (output valid, dst_lo, dst_hi, write_count, input ready);
	modport sink (input valid, dst_lo, dst_hi, write_count, output ready);
endinterface

// ----- sv/unary_float_int_convert.sv -----
// Top level of the unary float/int conversion lane: a three-stage pipeline.
// Depends on ufic_pkg and the channel interfaces in ufic_if.sv.
//
// channel   dir  fields
// in        in   command, src_lo, src_hi
// out       out  dst_lo, dst_hi, write_count
//
// An item accepted at a clock edge is written into the stage 1 register, then the stage 2
// register, then the output register; one item per cycle is sustained while out.ready is high.
// Stage 1 decodes and counts the leading zeros of the operand, stage 2 shifts,
// aligns and decides the rounding, stage 3 adds the rounding increment and packs.
// Reset clears the valid bits only. A stall holds the full stages from the output back to the
// first empty one; a stage takes a new item whenever it is empty or the stage after it moves.
module unary_float_int_convert (
	input  logic clk,
	input  logic arst_n,
	ufic_in_if.sink   in,
	ufic_out_if.source out
);
	localparam logic [ufic_pkg::CountW-1:0] CNT0 = 2'd0;
	localparam logic [ufic_pkg::CountW-1:0] CNT1 = 2'd1;
	localparam logic [ufic_pkg::CountW-1:0] CNT2 = 2'd2;

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3 = !v_s3 || out.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in.ready = adv1;

	function automatic logic [5:0] lz64(input logic [63:0] v);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) begin
				n = 6'(63 - i);
			end
		end
		return n;
	endfunction

	// Stage 1: decode, classify, build a left-justified magnitude.
	logic [3:0]  cmd_s1;
	logic [31:0] lo_s1, hi_s1;
	logic [63:0] nm_s1;
	logic [5:0]  lz_s1;
	logic        neg_s1;

	logic [63:0] mag_c;
	logic        neg_c;
	always_comb begin
		mag_c = 64'd0;
		neg_c = 1'b0;
		case (in.command)
			ufic_pkg::CMD_F32_I32, ufic_pkg::CMD_F64_I32: begin
				neg_c = in.src_lo[31];
				mag_c = {(in.src_lo[31] ? 32'd0 - in.src_lo : in.src_lo), 32'd0};
			end
			ufic_pkg::CMD_F32_U32: mag_c = {in.src_lo, 32'd0};
			ufic_pkg::CMD_F64_F32: mag_c = {in.src_lo[22:0], 41'd0};
			default: mag_c = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv1 && in.valid) begin
			cmd_s1 <= in.command;
			lo_s1 <= in.src_lo;
			hi_s1 <= in.src_hi;
			nm_s1 <= mag_c;
			lz_s1 <= lz64(mag_c);
			neg_s1 <= neg_c;
		end
	end

	// Stage 2: normalize or align, decide rounding, saturate.
	logic [3:0]  cmd_s2;
	logic [31:0] lo_s2, r_s2, rh_s2;
	logic [24:0] q_s2;
	logic        inc_s2;
	logic [1:0]  cnt_s2;

	logic [31:0] r_c, rh_c;
	logic [24:0] q_c;
	logic        inc_c;
	logic [1:0]  cnt_c;
	logic [63:0] nrm, dm;
	logic [7:0]  e8;
	logic [22:0] f23;
	logic [31:0] m32, q32;
	logic [10:0] e11;
	logic [51:0] f52;
	logic [5:0]  p;
	logic        rb, st;
	logic [8:0]  ex9;
	logic [11:0] ex;
	logic [63:0] m64, rm;
	logic [6:0]  sh;
	logic [53:0] q54;
	logic [31:0] tmask;
	always_comb begin
		r_c = 32'd0;
		rh_c = 32'd0;
		q_c = 25'd0;
		inc_c = 1'b0;
		cnt_c = CNT1;
		nrm = nm_s1 << lz_s1;
		p = 6'd63 - lz_s1;
		e8 = lo_s1[30:23];
		f23 = lo_s1[22:0];
		m32 = {1'b1, f23, 8'd0};
		q32 = 32'd0;
		e11 = hi_s1[30:20];
		f52 = {hi_s1[19:0], lo_s1};
		rb = 1'b0;
		st = 1'b0;
		ex9 = 9'd0;
		ex = 12'd0;
		m64 = 64'd0;
		rm = 64'd0;
		sh = 7'd0;
		q54 = 54'd0;
		dm = 64'd0;
		tmask = 32'd0;
		case (cmd_s1)
			ufic_pkg::CMD_MOV: r_c = lo_s1;
			ufic_pkg::CMD_NOT: r_c = ~lo_s1;
			ufic_pkg::CMD_F32_I32, ufic_pkg::CMD_F32_U32: begin
				if (nm_s1 != 64'd0) begin
					rb = nrm[39];
					st = nrm[38:0] != 39'd0;
					q_c = {1'b0, nrm[63:40]};
					inc_c = rb && (st || nrm[40]);
					r_c = {neg_s1, 8'd94 + {2'd0, p}, 23'd0};
				end
			end
			ufic_pkg::CMD_U32_F32, ufic_pkg::CMD_I32_F32: begin
				ex9 = {1'b0, e8} - 9'd127;
				if (e8 == 8'hFF && f23 != 23'd0) begin
					r_c = 32'd0;
				end else if (cmd_s1 == ufic_pkg::CMD_U32_F32 && lo_s1[31]) begin
					r_c = 32'd0;
				end else if (e8 < 8'd127) begin
					r_c = 32'd0;
				end else if (cmd_s1 == ufic_pkg::CMD_U32_F32 && ex9 >= 9'd32) begin
					r_c = 32'hFFFFFFFF;
				end else if (cmd_s1 == ufic_pkg::CMD_I32_F32 && ex9 >= 9'd31) begin
					r_c = lo_s1[31] ? 32'h80000000 : 32'h7FFFFFFF;
				end else begin
					q32 = m32 >> (5'd31 - ex9[4:0]);
					r_c = (cmd_s1 == ufic_pkg::CMD_I32_F32 && lo_s1[31])
						? 32'd0 - q32 : q32;
				end
			end
			ufic_pkg::CMD_F64_I32: begin
				cnt_c = CNT2;
				if (nm_s1 != 64'd0) begin
					rh_c = {neg_s1, 11'(11'd1023 + {5'd0, p} - 11'd32), nrm[62:43]};
					r_c = nrm[42:11];
				end
			end
			ufic_pkg::CMD_F32_F64: begin
				if (e11 == 11'h7FF) begin
					r_c = (f52 == 52'd0) ? {hi_s1[31], 31'h7F800000}
						: {hi_s1[31], 31'h7FC00000} | {9'd0, f52[51:29]};
				end else if (e11 == 11'd0) begin
					r_c = {hi_s1[31], 31'd0};
				end else begin
					ex = {1'b0, e11} - 12'd1023;
					if ($signed(ex) > 12'sd127) begin
						r_c = {hi_s1[31], 31'h7F800000};
					end else begin
						m64 = {11'd0, 1'b1, f52};
						if ($signed(ex) >= -12'sd126) begin
							sh = 7'd29;
						end else if ($signed(ex) < -12'sd157) begin
							sh = 7'd60;
						end else begin
							sh = 7'(12'd29 + (12'd0 - 12'd126 - ex));
						end
						q54 = 54'(m64 >> sh);
						rm = m64 & ((64'd1 << sh) - 64'd1);
						dm = 64'd1 << (sh - 7'd1);
						q_c = q54[24:0];
						inc_c = rm > dm || (rm == dm && q54[0]);
						if ($signed(ex) >= -12'sd126) begin
							r_c = {hi_s1[31], 8'(ex + 12'd126), 23'd0};
						end else begin
							r_c = {hi_s1[31], 31'd0};
						end
					end
				end
			end
			ufic_pkg::CMD_F64_F32: begin
				cnt_c = CNT2;
				if (e8 == 8'hFF) begin
					rh_c = (f23 == 23'd0) ? {lo_s1[31], 31'h7FF00000}
						: {lo_s1[31], 31'h7FF80000} | {12'd0, f23[22:3]};
					r_c = {f23[2:0], 29'd0};
				end else if (e8 == 8'd0) begin
					if (f23 != 23'd0) begin
						rh_c = {lo_s1[31], 11'(11'd874 + {5'd0, p} - 11'd41),
							nrm[62:43]};
						r_c = nrm[42:11];
					end else begin
						rh_c = {lo_s1[31], 31'd0};
					end
				end else begin
					rh_c = {lo_s1[31], 11'({3'd0, e8} + 11'd896), f23[22:3]};
					r_c = {f23[2:0], 29'd0};
				end
			end
			ufic_pkg::CMD_TRUNC: begin
				if (e8 == 8'hFF) begin
					r_c = (f23 != 23'd0) ? (lo_s1 | 32'h00400000) : lo_s1;
				end else if (e8 < 8'd127) begin
					r_c = {lo_s1[31], 31'd0};
				end else if (e8 >= 8'd150) begin
					r_c = lo_s1;
				end else begin
					tmask = (32'd1 << 5'(8'd150 - e8)) - 32'd1;
					r_c = lo_s1 & ~tmask;
				end
			end
			ufic_pkg::CMD_SEXT: begin
				cnt_c = CNT2;
				r_c = lo_s1;
				rh_c = {32{lo_s1[31]}};
			end
			default: cnt_c = CNT0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			cmd_s2 <= cmd_s1;
			lo_s2 <= lo_s1;
			r_s2 <= r_c;
			rh_s2 <= rh_c;
			q_s2 <= q_c;
			inc_s2 <= inc_c;
			cnt_s2 <= cnt_c;
		end
	end

	// Stage 3: add the rounded mantissa into the packed word, output register.
	logic [31:0] r_s3, rh_s3;
	logic [1:0]  cnt_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			r_s3 <= r_s2 + {7'd0, q_s2 + {24'd0, inc_s2}};
			rh_s3 <= (cnt_s2 == CNT2) ? rh_s2 : 32'd0;
			cnt_s3 <= cnt_s2;
		end
	end

	assign out.valid = v_s3;
	assign out.dst_lo = r_s3;
	assign out.dst_hi = rh_s3;
	assign out.write_count = cnt_s3;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.dst_lo))
		else $error("output item changed under stall");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> out.write_count != 2'd3)
		else $error("bad write count");
	a_hi: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.write_count != CNT2 |-> out.dst_hi == 32'd0)
		else $error("high word not zero");
	a_mov: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && adv3 && cmd_s2 == ufic_pkg::CMD_MOV |=> out.dst_lo == $past(lo_s2))
		else $error("mov mismatch");
endmodule
